// File: rtl/core/qdd_pkg.sv
`default_nettype none

package qdd_pkg;

  // Field and state widths
  localparam int DELTA_W   = 16;
  localparam int CFG_W     = 4;
  localparam int QSUM_W    = 5;
  localparam int COUNT_W_DEF = 16;

  // Item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Reset values
  localparam logic [CFG_W-1:0] QPD_RESET = 4'd4;
  localparam logic [1:0]       PINS_IDLE = 2'b11;

  // Gray-code transition table: {prev A, prev B, new A, new B} -> quarter step
  function automatic logic signed [1:0] quarter_step(input logic [3:0] idx);
    logic signed [1:0] q;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: q = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: q = 2'sd1;
      default: q = 2'sd0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/quadrature_detent_decoder_unit.sv
// Rotary quadrature decoder with detent counting.
// Input channel (in_valid / in_stall): one beat carries op, pin_a and pin_b.
//   op = sample: the A/B levels are decoded against the previous levels into
//   a quarter step; quarter steps build up until they reach the detent size
//   programmed through the configuration port, then the detent counter moves
//   by one (saturating) and the quarter sum clears. The result delta is 0.
//   op = read: delta returns the detent count (clamped to 16 bits) and the
//   count clears. Pin levels are ignored on a read.
// Output channel (out_valid / out_stall): exactly one delta beat per input.
// An accepted beat's delta is registered in the output register, or in the
// skid register behind a stalled output. Throughput is one item per cycle
// while in_stall is low, set by the single decode-and-add pass per beat.
// A stalled output keeps its beat; one further input beat is still accepted
// into a skid register, and in_stall rises only while that register is full.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes the detent size and
// is always ready; write it only while no beat is in flight.
// Synchronous reset sets the previous pins to both-high, clears the quarter
// sum and the detent count, empties both output registers, and sets size 4.
`default_nettype none

module quadrature_detent_decoder_unit #(
  parameter int COUNT_WIDTH = qdd_pkg::COUNT_W_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 op,
  input  wire                                 pin_a,
  input  wire                                 pin_b,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [qdd_pkg::DELTA_W-1:0]  delta,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire         [qdd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DW    = qdd_pkg::DELTA_W;
  localparam int QW    = qdd_pkg::QSUM_W;
  localparam int EXT_W = (COUNT_WIDTH > DW) ? COUNT_WIDTH : DW;

  localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CMIN = ~CMAX;
  localparam logic signed [EXT_W-1:0] DMAX = {{(EXT_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] DMIN = ~DMAX;

  logic [qdd_pkg::CFG_W-1:0]     qpd;
  logic [1:0]                    prev_pins;
  logic signed [QW-1:0]          quarter_sum;
  logic signed [COUNT_WIDTH-1:0] detent_count;
  logic signed [DW-1:0]          skid_delta;
  logic                          skid_valid;

  logic [1:0]                    pins_now;
  logic signed [1:0]             qstep;
  logic signed [QW:0]            sum_add;
  logic signed [QW:0]            limit_pos;
  logic signed [QW:0]            limit_neg;
  logic signed [QW-1:0]          quarter_sum_next;
  logic signed [COUNT_WIDTH-1:0] detent_count_next;
  logic signed [EXT_W-1:0]       cnt_ext;
  logic signed [DW-1:0]          result;
  logic                          in_acc;
  logic                          out_take;

  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Decode the transition and build up quarter steps
  assign pins_now  = {pin_a, pin_b};
  assign qstep     = qdd_pkg::quarter_step({prev_pins, pins_now});
  assign sum_add   = (QW+1)'(quarter_sum) + (QW+1)'(qstep);
  assign limit_pos = signed'({2'b00, qpd});
  assign limit_neg = -limit_pos;

  // Clamp the count to the delta range
  assign cnt_ext = EXT_W'(detent_count);

  always_comb begin
    if (cnt_ext > DMAX) begin
      result = DMAX[DW-1:0];
    end else if (cnt_ext < DMIN) begin
      result = DMIN[DW-1:0];
    end else begin
      result = cnt_ext[DW-1:0];
    end
  end

  // Next sum and count for one beat
  always_comb begin
    quarter_sum_next  = quarter_sum;
    detent_count_next = detent_count;
    if (op == qdd_pkg::OP_READ) begin
      detent_count_next = '0;
    end else if (qstep != 2'sd0) begin
      if (sum_add >= limit_pos) begin
        quarter_sum_next = '0;
        if (detent_count != CMAX) begin
          detent_count_next = detent_count + COUNT_WIDTH'(1);
        end
      end else if (sum_add <= limit_neg) begin
        quarter_sum_next = '0;
        if (detent_count != CMIN) begin
          detent_count_next = detent_count - COUNT_WIDTH'(1);
        end
      end else begin
        quarter_sum_next = sum_add[QW-1:0];
      end
    end
  end

  // Hold decoder state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      qpd          <= qdd_pkg::QPD_RESET;
      prev_pins    <= qdd_pkg::PINS_IDLE;
      quarter_sum  <= '0;
      detent_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        qpd <= cfg_data;
      end
      if (in_acc) begin
        quarter_sum  <= quarter_sum_next;
        detent_count <= detent_count_next;
        if (op == qdd_pkg::OP_SAMPLE) begin
          prev_pins <= pins_now;
        end
      end
    end
  end

  // Output register with one skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        delta      <= skid_delta;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        delta <= (op == qdd_pkg::OP_READ) ? result : '0;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid) begin
        delta     <= (op == qdd_pkg::OP_READ) ? result : '0;
        out_valid <= 1'b1;
      end else begin
        skid_delta <= (op == qdd_pkg::OP_READ) ? result : '0;
        skid_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  // Skid stage only fills behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A read clears the detent count
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == qdd_pkg::OP_READ) |=> (detent_count == '0))
    else $error("detent count not cleared after read");

  // Quarter sum never reaches the bottom code
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    quarter_sum != {1'b1, {(QW-1){1'b0}}})
    else $error("quarter sum out of range");

  // A taken beat with nothing behind it empties the output
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_take && !skid_valid && !in_acc) |=> !out_valid)
    else $error("output beat repeated");

  // A sample beat leaves a zero delta
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == qdd_pkg::OP_SAMPLE && !out_valid) |=> (delta == '0))
    else $error("sample beat produced nonzero delta");
`endif

endmodule

`default_nettype wire
